[rtl/pssc_pkg.sv]
`default_nettype none

package pssc_pkg;

   localparam int GRID_SIZE_DEF = 16;
   localparam int POS_W = 4;
   localparam int COLOUR_W = 32;

   localparam logic [COLOUR_W-1:0] OPAQUE_BLACK = 32'h0000_00FF;

   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_CENTRE = 1'b1;

   typedef enum logic [2:0] {
      OP_CLEAR      = 3'd0,
      OP_SET_SEL    = 3'd1,
      OP_SET_COLOUR = 3'd2,
      OP_SET_TRANS  = 3'd3,
      OP_READ       = 3'd4,
      OP_CENTRE     = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_DRAIN,
      ST_DONE
   } state_type;

   typedef struct packed {
      op_type               operation;
      logic [POS_W-1:0]     pos_x;
      logic [POS_W-1:0]     pos_y;
      logic                 selected_in;
      logic [COLOUR_W-1:0]  colour_in;
      logic                 transparent_in;
      logic                 skip_transparent;
   } req_type;

   typedef struct packed {
      logic                 result_kind;
      logic                 selected_out;
      logic [COLOUR_W-1:0]  colour_out;
      logic                 transparent_out;
      logic [POS_W-1:0]     centre_x;
      logic [POS_W-1:0]     centre_y;
   } rsp_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;
      logic sweep_rst;
      logic sweep_step;
      logic clear_wr;
      logic scan_rd;
      logic load_read;
      logic load_centre;
   } ctl_cmd_type;

   typedef struct packed {
      logic sweep_last;
   } dp_status_type;

endpackage

`default_nettype wire

[rtl/pixel_selection_store_center.sv]
// Pixel selection store: a GRID_SIZE x GRID_SIZE grid, each pixel holding a
// selected flag, an RGBA colour and a transparent flag.
// Requests arrive on the req_ channel (valid/ready); each carries an operation
// code and its operands. Reads and centre queries produce one transfer on the
// rsp_ channel; clear, the set operations and unused codes produce none.
// Set operations may follow back to back.
// A read passes through ST_READ: the pixel memories have a registered read port,
// so the result is loaded into the output register from ST_READ once it is free.
// A centre query scans the grid one cell per clock through the same read
// port, then passes through ST_DRAIN and ST_DONE before the result is loaded.
// A clear sweeps the grid one cell per clock.
// Reset runs the same clearing sweep; req_ready stays low until it is done.
// The result sits in an output register. While the receiver stalls, new
// write requests are still taken; a read or centre query waits with its
// result until the output register is free.
`default_nettype none

module pixel_selection_store_center #(
   parameter int GRID_SIZE = pssc_pkg::GRID_SIZE_DEF
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_ready,
   input  pssc_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_ready,
   output pssc_pkg::rsp_type  rsp_data
);

   pssc_pkg::ctl_cmd_type   cmd;
   pssc_pkg::dp_status_type status;

   pssc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_data.operation),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   pssc_datapath #(
      .GRID_SIZE (GRID_SIZE)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

[rtl/pssc_datapath.sv]
`default_nettype none

module pssc_datapath #(
   parameter int GRID_SIZE = pssc_pkg::GRID_SIZE_DEF
) (
   input  wire                     clock,
   input  wire                     reset,
   input  pssc_pkg::req_type       req_data,
   input  pssc_pkg::ctl_cmd_type   cmd,
   output pssc_pkg::dp_status_type status,
   output pssc_pkg::rsp_type       rsp_data
);

   localparam int CELLS = GRID_SIZE * GRID_SIZE;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int COORD_W = $clog2(GRID_SIZE);
   localparam int MM_W = $clog2(GRID_SIZE + 1);
   localparam int SUM_W = MM_W + pssc_pkg::POS_W;
   localparam logic [COORD_W-1:0] COORD_LAST = COORD_W'(GRID_SIZE - 1);

   logic                          sel_mem [CELLS];
   logic                          trans_mem [CELLS];
   logic [pssc_pkg::COLOUR_W-1:0] colour_mem [CELLS];

   logic [COORD_W-1:0] x_ff, x_in, y_ff, y_in;
   logic [COORD_W-1:0] sx_ff, sy_ff;
   logic               scan_vld_ff;
   logic               skip_ff;
   logic               read_inside_ff;
   logic               sel_rd_ff, trans_rd_ff;
   logic [pssc_pkg::COLOUR_W-1:0] colour_rd_ff;
   logic [MM_W-1:0]    minx_ff, maxx_ff, miny_ff, maxy_ff;
   pssc_pkg::rsp_type  rsp_ff;

   logic               on_grid;
   logic [ADDR_W-1:0]  req_addr, sweep_addr, wr_addr, rd_addr;
   logic               sel_we, trans_we, colour_we, rd_en;
   logic               sel_wd, trans_wd;
   logic [pssc_pkg::COLOUR_W-1:0] colour_wd;
   logic               hit;
   logic [MM_W-1:0]    sx_ext, sy_ext;
   logic [SUM_W-1:0]   sum_x, sum_y;

   assign on_grid = (int'(req_data.pos_x) < GRID_SIZE) && (int'(req_data.pos_y) < GRID_SIZE);
   assign req_addr = ADDR_W'(int'(req_data.pos_y) * GRID_SIZE + int'(req_data.pos_x));
   assign sweep_addr = ADDR_W'(int'(y_ff) * GRID_SIZE + int'(x_ff));

   // Sweep counters walk the grid row by row for both clearing and the centre scan.
   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (cmd.sweep_rst) begin
         x_in = '0;
         y_in = '0;
      end else if (cmd.sweep_step) begin
         if (x_ff == COORD_LAST) begin
            x_in = '0;
            y_in = (y_ff == COORD_LAST) ? '0 : y_ff + 1'b1;
         end else begin
            x_in = x_ff + 1'b1;
         end
      end
   end

   assign status.sweep_last = (x_ff == COORD_LAST) && (y_ff == COORD_LAST);

   always_comb begin
      sel_we = 1'b0;
      trans_we = 1'b0;
      colour_we = 1'b0;
      rd_en = cmd.scan_rd;
      sel_wd = 1'b0;
      trans_wd = 1'b0;
      colour_wd = pssc_pkg::OPAQUE_BLACK;
      wr_addr = cmd.clear_wr ? sweep_addr : req_addr;
      rd_addr = cmd.scan_rd ? sweep_addr : req_addr;
      if (cmd.clear_wr) begin
         sel_we = 1'b1;
         trans_we = 1'b1;
         colour_we = 1'b1;
      end else if (cmd.accept) begin
         case (req_data.operation)
            pssc_pkg::OP_SET_SEL: begin
               sel_we = on_grid;
               sel_wd = req_data.selected_in;
            end
            pssc_pkg::OP_SET_COLOUR: begin
               colour_we = on_grid;
               colour_wd = req_data.colour_in;
            end
            pssc_pkg::OP_SET_TRANS: begin
               trans_we = on_grid;
               trans_wd = req_data.transparent_in;
            end
            pssc_pkg::OP_READ: begin
               rd_en = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (sel_we) sel_mem[wr_addr] <= sel_wd;
      if (trans_we) trans_mem[wr_addr] <= trans_wd;
      if (colour_we) colour_mem[wr_addr] <= colour_wd;
      if (rd_en) begin
         sel_rd_ff <= sel_mem[rd_addr];
         trans_rd_ff <= trans_mem[rd_addr];
         colour_rd_ff <= colour_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
         scan_vld_ff <= 1'b0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
         scan_vld_ff <= cmd.scan_rd;
      end
   end

   assign hit = scan_vld_ff && sel_rd_ff && !(skip_ff && trans_rd_ff);
   assign sx_ext = MM_W'(sx_ff);
   assign sy_ext = MM_W'(sy_ff);

   always_ff @(posedge clock) begin
      if (cmd.scan_rd) begin
         sx_ff <= x_ff;
         sy_ff <= y_ff;
      end
      if (cmd.accept && req_data.operation == pssc_pkg::OP_READ) begin
         read_inside_ff <= on_grid;
      end
      if (cmd.accept && req_data.operation == pssc_pkg::OP_CENTRE) begin
         skip_ff <= req_data.skip_transparent;
         minx_ff <= MM_W'(GRID_SIZE);
         miny_ff <= MM_W'(GRID_SIZE);
         maxx_ff <= '0;
         maxy_ff <= '0;
      end else if (hit) begin
         if (sx_ext < minx_ff) minx_ff <= sx_ext;
         if (sy_ext < miny_ff) miny_ff <= sy_ext;
         if (sx_ext > maxx_ff) maxx_ff <= sx_ext;
         if (sy_ext > maxy_ff) maxy_ff <= sy_ext;
      end
   end

   assign sum_x = (SUM_W'(minx_ff) + SUM_W'(maxx_ff)) >> 1;
   assign sum_y = (SUM_W'(miny_ff) + SUM_W'(maxy_ff)) >> 1;

   always_ff @(posedge clock) begin
      if (cmd.load_read) begin
         rsp_ff.result_kind <= pssc_pkg::KIND_READ;
         rsp_ff.selected_out <= read_inside_ff & sel_rd_ff;
         rsp_ff.colour_out <= read_inside_ff ? colour_rd_ff : '0;
         rsp_ff.transparent_out <= read_inside_ff & trans_rd_ff;
         rsp_ff.centre_x <= '0;
         rsp_ff.centre_y <= '0;
      end else if (cmd.load_centre) begin
         rsp_ff.result_kind <= pssc_pkg::KIND_CENTRE;
         rsp_ff.selected_out <= 1'b0;
         rsp_ff.colour_out <= '0;
         rsp_ff.transparent_out <= 1'b0;
         rsp_ff.centre_x <= sum_x[pssc_pkg::POS_W-1:0];
         rsp_ff.centre_y <= sum_y[pssc_pkg::POS_W-1:0];
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

[rtl/pssc_ctrl.sv]
`default_nettype none

module pssc_ctrl (
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     req_valid,
   output logic                    req_ready,
   input  pssc_pkg::op_type        req_op,
   output logic                    rsp_valid,
   input  wire                     rsp_ready,
   input  pssc_pkg::dp_status_type status,
   output pssc_pkg::ctl_cmd_type   cmd
);

   pssc_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pssc_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      case (state_ff)
         pssc_pkg::ST_CLEAR: begin
            cmd.clear_wr = 1'b1;
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) state_in = pssc_pkg::ST_IDLE;
         end
         pssc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               case (req_op)
                  pssc_pkg::OP_CLEAR: begin
                     cmd.sweep_rst = 1'b1;
                     state_in = pssc_pkg::ST_CLEAR;
                  end
                  pssc_pkg::OP_READ: begin
                     state_in = pssc_pkg::ST_READ;
                  end
                  pssc_pkg::OP_CENTRE: begin
                     cmd.sweep_rst = 1'b1;
                     state_in = pssc_pkg::ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         pssc_pkg::ST_READ: begin
            if (slot_free) begin
               cmd.load_read = 1'b1;
               state_in = pssc_pkg::ST_IDLE;
            end
         end
         pssc_pkg::ST_SCAN: begin
            cmd.scan_rd = 1'b1;
            cmd.sweep_step = 1'b1;
            if (status.sweep_last) state_in = pssc_pkg::ST_DRAIN;
         end
         pssc_pkg::ST_DRAIN: begin
            // The last cell read is folded into the bounding box at this edge.
            state_in = pssc_pkg::ST_DONE;
         end
         pssc_pkg::ST_DONE: begin
            if (slot_free) begin
               cmd.load_centre = 1'b1;
               state_in = pssc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = pssc_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_read || cmd.load_centre) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   a_reset_clears: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> state_ff == pssc_pkg::ST_CLEAR)
      else $error("grid clear does not follow reset");

   a_load_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_read || cmd.load_centre) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result loaded over a pending transfer");

   a_read_path: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && req_op == pssc_pkg::OP_READ) |=> state_ff == pssc_pkg::ST_READ)
      else $error("read transfer did not enter read state");

   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == pssc_pkg::ST_SCAN && status.sweep_last) |=> state_ff == pssc_pkg::ST_DRAIN)
      else $error("scan did not drain after the last cell");

   a_centre_once: assert property (@(posedge clock) disable iff (reset)
      cmd.load_centre |=> !cmd.load_centre && state_ff == pssc_pkg::ST_IDLE)
      else $error("centre result loaded twice");

endmodule

`default_nettype wire
